// File: rtl/grr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the 5x5 font for the glyph-to-rect rasteriser.
// Used by grr_front, grr_queue, grr_back and glyph_to_rect_rasterizer.
package grr_pkg;

  localparam int GLYPH_CELLS  = 5;
  localparam int CELL_COUNT   = GLYPH_CELLS * GLYPH_CELLS;
  localparam int FONT_ENTRIES = 42;
  localparam int DIGIT_BASE   = 27;
  localparam int MARK_BASE    = 37;

  localparam int START_BITS  = 12;
  localparam int CODE_BITS   = 8;
  localparam int COLOR_BITS  = 16;
  localparam int SCALE_BITS  = 4;
  localparam int PANEL_BITS  = 10;
  localparam int OFFSET_BITS = 8;
  localparam int WIN_BITS    = 11;
  localparam int COUNT_BITS  = 8;
  localparam int INDEX_BITS  = 6;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [COLOR_BITS-1:0] TRANSPARENT = 16'hFFFF;

  localparam logic [PANEL_BITS-1:0]  PANEL_WIDTH_RESET  = 10'd320;
  localparam logic [PANEL_BITS-1:0]  PANEL_HEIGHT_RESET = 10'd170;
  localparam logic [OFFSET_BITS-1:0] X_OFFSET_RESET     = 8'd0;
  localparam logic [OFFSET_BITS-1:0] Y_OFFSET_RESET     = 8'd35;

  // Register map, word index into the configuration space
  typedef enum logic [1:0] {
    REG_PANEL_WIDTH,
    REG_PANEL_HEIGHT,
    REG_X_OFFSET,
    REG_Y_OFFSET
  } reg_index_t;

  // Clipped extent of one glyph column or row
  typedef struct packed {
    logic [PANEL_BITS-1:0] lo;
    logic [PANEL_BITS-1:0] hi;
    logic [SCALE_BITS-1:0] len;
  } span_t;

  // One classified character; cell bits are column-major (col*5 + row)
  typedef struct packed {
    logic [CELL_COUNT-1:0]   mask;
    logic [CELL_COUNT-1:0]   glyph;
    span_t [GLYPH_CELLS-1:0] cols;
    span_t [GLYPH_CELLS-1:0] rows;
    logic [COLOR_BITS-1:0]   fg;
    logic [COLOR_BITS-1:0]   bg;
  } entry_t;

  // Font rows, bit 4 is the leftmost column
  localparam logic [GLYPH_CELLS-1:0] FONT [FONT_ENTRIES][GLYPH_CELLS] = '{
    '{5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h0E,5'h11,5'h1F,5'h11,5'h11}, '{5'h1E,5'h11,5'h1E,5'h11,5'h1E},
    '{5'h0F,5'h10,5'h10,5'h10,5'h0F}, '{5'h1E,5'h11,5'h11,5'h11,5'h1E},
    '{5'h1F,5'h10,5'h1E,5'h10,5'h1F}, '{5'h1F,5'h10,5'h1E,5'h10,5'h10},
    '{5'h0F,5'h10,5'h17,5'h11,5'h0F}, '{5'h11,5'h11,5'h1F,5'h11,5'h11},
    '{5'h1F,5'h04,5'h04,5'h04,5'h1F}, '{5'h07,5'h02,5'h02,5'h12,5'h0C},
    '{5'h11,5'h12,5'h1C,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h1F},
    '{5'h11,5'h1B,5'h15,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11},
    '{5'h0E,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h1E,5'h10,5'h10},
    '{5'h0E,5'h11,5'h11,5'h15,5'h0E}, '{5'h1E,5'h11,5'h1E,5'h12,5'h11},
    '{5'h0F,5'h10,5'h0E,5'h01,5'h1E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04},
    '{5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h0A,5'h04},
    '{5'h11,5'h11,5'h15,5'h1B,5'h11}, '{5'h11,5'h0A,5'h04,5'h0A,5'h11},
    '{5'h11,5'h0A,5'h04,5'h04,5'h04}, '{5'h1F,5'h02,5'h04,5'h08,5'h1F},
    '{5'h0E,5'h11,5'h11,5'h11,5'h0E}, '{5'h04,5'h0C,5'h04,5'h04,5'h0E},
    '{5'h0E,5'h11,5'h02,5'h04,5'h1F}, '{5'h1E,5'h01,5'h06,5'h01,5'h1E},
    '{5'h12,5'h12,5'h1F,5'h02,5'h02}, '{5'h1F,5'h10,5'h1E,5'h01,5'h1E},
    '{5'h07,5'h08,5'h1E,5'h11,5'h0E}, '{5'h1F,5'h01,5'h02,5'h04,5'h04},
    '{5'h0E,5'h11,5'h0E,5'h11,5'h0E}, '{5'h0E,5'h11,5'h0F,5'h01,5'h0E},
    '{5'h00,5'h04,5'h00,5'h04,5'h00}, '{5'h00,5'h00,5'h1F,5'h00,5'h00},
    '{5'h00,5'h00,5'h00,5'h06,5'h06}, '{5'h01,5'h02,5'h04,5'h08,5'h10},
    '{5'h00,5'h0E,5'h00,5'h0E,5'h00}
  };

  // Map a character code to its font entry; unknown codes draw blank
  function automatic logic [INDEX_BITS-1:0] glyph_index(input logic [CODE_BITS-1:0] code);
    logic [INDEX_BITS-1:0] idx;
    idx = '0;
    if (code >= 8'h41 && code <= 8'h5A) begin
      idx = INDEX_BITS'(code - 8'h40);
    end else if (code >= 8'h30 && code <= 8'h39) begin
      idx = INDEX_BITS'(code - 8'h30) + INDEX_BITS'(DIGIT_BASE);
    end else begin
      unique case (code)
        8'h3A:   idx = INDEX_BITS'(MARK_BASE);
        8'h2D:   idx = INDEX_BITS'(MARK_BASE + 1);
        8'h2E:   idx = INDEX_BITS'(MARK_BASE + 2);
        8'h2F:   idx = INDEX_BITS'(MARK_BASE + 3);
        8'h3D:   idx = INDEX_BITS'(MARK_BASE + 4);
        default: idx = '0;
      endcase
    end
    return idx;
  endfunction

  // Glyph cells of a code, column-major
  function automatic logic [CELL_COUNT-1:0] glyph_bits(input logic [CODE_BITS-1:0] code);
    logic [INDEX_BITS-1:0] idx;
    logic [CELL_COUNT-1:0] bits;
    idx  = glyph_index(code);
    bits = '0;
    for (int c = 0; c < GLYPH_CELLS; c++) begin
      for (int r = 0; r < GLYPH_CELLS; r++) begin
        if (idx < INDEX_BITS'(FONT_ENTRIES)) begin
          bits[c*GLYPH_CELLS + r] = FONT[idx][r][GLYPH_CELLS-1-c];
        end
      end
    end
    return bits;
  endfunction

endpackage

// File: rtl/glyph_to_rect_rasterizer.sv
`timescale 1ns / 1ps
// Glyph-to-rect rasteriser top level: configuration registers and the
// front end, queue and back end. Depends on grr_pkg, grr_front, grr_queue, grr_back.
//
// Each accepted word is one character, drawn from a built-in 5x5 font as up to
// 25 clipped squares (column by column, top to bottom), each a panel address
// window with offsets, a fill colour and a pixel count; last_rect marks the
// final square of a character. The front end takes one word per cycle while
// item_stall is low, updates the pen (advance 6*scale, saturating) and clips
// the glyph grid; the back end sends one square per cycle from the single
// result register while rect_stall is low, and a character with nothing to
// draw sends no square. A queue of QUEUE_DEPTH characters sits between the
// two ends. Registers: panel_width at 0x0, panel_height at 0x4,
// window_x_offset at 0x8, window_y_offset at 0xC; write them only while the
// block is idle.
module glyph_to_rect_rasterizer #(
  parameter int COORD_BITS  = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [grr_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [grr_pkg::DATA_BITS-1:0]        pwdata,
  output logic [grr_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 new_string,
  input  logic signed [grr_pkg::START_BITS-1:0] start_x,
  input  logic signed [grr_pkg::START_BITS-1:0] start_y,
  input  logic [grr_pkg::CODE_BITS-1:0]        char_code,
  input  logic [grr_pkg::COLOR_BITS-1:0]       fg_color,
  input  logic [grr_pkg::COLOR_BITS-1:0]       bg_color,
  input  logic [grr_pkg::SCALE_BITS-1:0]       scale,
  output logic                                 rect_valid,
  input  logic                                 rect_stall,
  output logic [grr_pkg::WIN_BITS-1:0]         win_x0,
  output logic [grr_pkg::WIN_BITS-1:0]         win_y0,
  output logic [grr_pkg::WIN_BITS-1:0]         win_x1,
  output logic [grr_pkg::WIN_BITS-1:0]         win_y1,
  output logic [grr_pkg::COLOR_BITS-1:0]       fill_color,
  output logic [grr_pkg::COUNT_BITS-1:0]       pixel_count,
  output logic                                 last_rect
);

  logic [grr_pkg::PANEL_BITS-1:0]  panel_width;
  logic [grr_pkg::PANEL_BITS-1:0]  panel_height;
  logic [grr_pkg::OFFSET_BITS-1:0] window_x_offset;
  logic [grr_pkg::OFFSET_BITS-1:0] window_y_offset;
  logic                            cfg_write;
  grr_pkg::reg_index_t             reg_sel;
  logic                            push;
  logic                            pop;
  logic                            queue_full;
  logic                            head_valid;
  grr_pkg::entry_t                 push_entry;
  grr_pkg::entry_t                 head;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_sel   = grr_pkg::reg_index_t'(paddr[grr_pkg::ADDR_BITS-1:2]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width     <= grr_pkg::PANEL_WIDTH_RESET;
      panel_height    <= grr_pkg::PANEL_HEIGHT_RESET;
      window_x_offset <= grr_pkg::X_OFFSET_RESET;
      window_y_offset <= grr_pkg::Y_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        grr_pkg::REG_PANEL_WIDTH:  panel_width     <= pwdata[grr_pkg::PANEL_BITS-1:0];
        grr_pkg::REG_PANEL_HEIGHT: panel_height    <= pwdata[grr_pkg::PANEL_BITS-1:0];
        grr_pkg::REG_X_OFFSET:     window_x_offset <= pwdata[grr_pkg::OFFSET_BITS-1:0];
        grr_pkg::REG_Y_OFFSET:     window_y_offset <= pwdata[grr_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      grr_pkg::REG_PANEL_WIDTH:  prdata = grr_pkg::DATA_BITS'(panel_width);
      grr_pkg::REG_PANEL_HEIGHT: prdata = grr_pkg::DATA_BITS'(panel_height);
      grr_pkg::REG_X_OFFSET:     prdata = grr_pkg::DATA_BITS'(window_x_offset);
      grr_pkg::REG_Y_OFFSET:     prdata = grr_pkg::DATA_BITS'(window_y_offset);
      default:                   prdata = '0;
    endcase
  end

  grr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .new_string   (new_string),
    .start_x      (start_x),
    .start_y      (start_y),
    .char_code    (char_code),
    .fg_color     (fg_color),
    .bg_color     (bg_color),
    .scale        (scale),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  grr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  grr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .window_x_offset (window_x_offset),
    .window_y_offset (window_y_offset),
    .rect_valid      (rect_valid),
    .rect_stall      (rect_stall),
    .win_x0          (win_x0),
    .win_y0          (win_y0),
    .win_x1          (win_x1),
    .win_y1          (win_y1),
    .fill_color      (fill_color),
    .pixel_count     (pixel_count),
    .last_rect       (last_rect)
  );

endmodule

// File: rtl/grr_front.sv
`timescale 1ns / 1ps
// Front end: takes character words, keeps the pen, clips the glyph grid.
// Depends on grr_pkg; feeds grr_queue.
module grr_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 new_string,
  input  logic signed [grr_pkg::START_BITS-1:0] start_x,
  input  logic signed [grr_pkg::START_BITS-1:0] start_y,
  input  logic [grr_pkg::CODE_BITS-1:0]        char_code,
  input  logic [grr_pkg::COLOR_BITS-1:0]       fg_color,
  input  logic [grr_pkg::COLOR_BITS-1:0]       bg_color,
  input  logic [grr_pkg::SCALE_BITS-1:0]       scale,
  input  logic [grr_pkg::PANEL_BITS-1:0]       panel_width,
  input  logic [grr_pkg::PANEL_BITS-1:0]       panel_height,
  input  logic                                 queue_full,
  output logic                                 push,
  output grr_pkg::entry_t                      push_entry
);

  localparam int WIDE = grr_pkg::START_BITS + COORD_BITS;
  localparam int AW   = COORD_BITS + 1;
  localparam int XW   = COORD_BITS + 2;

  localparam logic signed [WIDE-1:0] START_MAX =
    {{(WIDE-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [WIDE-1:0] START_MIN = ~START_MAX;
  localparam logic signed [AW-1:0] PEN_MAX = {2'b00, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic           vis;
    grr_pkg::span_t span;
  } clip_t;

  // Saturate a 12-bit start position into the pen range
  function automatic logic signed [COORD_BITS-1:0] sat_start(
    input logic signed [grr_pkg::START_BITS-1:0] v
  );
    logic signed [WIDE-1:0] w;
    logic signed [WIDE-1:0] s;
    w = WIDE'(v);
    if (w > START_MAX) begin
      s = START_MAX;
    end else if (w < START_MIN) begin
      s = START_MIN;
    end else begin
      s = w;
    end
    return s[COORD_BITS-1:0];
  endfunction

  // Clip one cell-wide strip [pos, pos+side) against [0, limit)
  function automatic clip_t clip(
    input logic signed [XW-1:0]           pos,
    input logic [grr_pkg::SCALE_BITS-1:0] side,
    input logic [grr_pkg::PANEL_BITS-1:0] limit
  );
    logic signed [XW-1:0] lim_s;
    logic signed [XW-1:0] lo_s;
    logic signed [XW-1:0] end_s;
    logic signed [XW-1:0] hi_s;
    logic signed [XW-1:0] len_s;
    clip_t                res;
    lim_s = XW'({1'b0, limit});
    end_s = pos + XW'({1'b0, side});
    lo_s  = (pos < 0) ? '0 : pos;
    if (end_s > lim_s) begin
      end_s = lim_s;
    end
    len_s        = end_s - lo_s;
    hi_s         = end_s - XW'(1);
    res.vis      = len_s > 0;
    res.span.lo  = lo_s[grr_pkg::PANEL_BITS-1:0];
    res.span.hi  = hi_s[grr_pkg::PANEL_BITS-1:0];
    res.span.len = len_s[grr_pkg::SCALE_BITS-1:0];
    return res;
  endfunction

  logic                                 accept;
  logic signed [COORD_BITS-1:0]         pen_col;
  logic signed [COORD_BITS-1:0]         pen_row;
  logic signed [COORD_BITS-1:0]         pen_col_next;
  logic signed [COORD_BITS-1:0]         cur_col;
  logic signed [COORD_BITS-1:0]         cur_row;
  logic                                 stage_valid;
  logic                                 stage_valid_next;
  logic signed [COORD_BITS-1:0]         stage_col;
  logic signed [COORD_BITS-1:0]         stage_row;
  logic [grr_pkg::CODE_BITS-1:0]        stage_code;
  logic [grr_pkg::COLOR_BITS-1:0]       stage_fg;
  logic [grr_pkg::COLOR_BITS-1:0]       stage_bg;
  logic [grr_pkg::SCALE_BITS-1:0]       stage_scale;

  assign item_stall = stage_valid & queue_full;
  assign accept     = item_valid & ~item_stall;
  assign push       = stage_valid & ~queue_full;

  // Resolve the pen for this word and work out the advanced pen
  always_comb begin
    logic signed [AW-1:0] adv;
    logic [6:0]           step;
    cur_col = new_string ? sat_start(start_x) : pen_col;
    cur_row = new_string ? sat_start(start_y) : pen_row;
    step    = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};
    adv     = AW'(cur_col) + AW'({1'b0, step});
    pen_col_next = (adv > PEN_MAX) ? PEN_MAX[COORD_BITS-1:0] : adv[COORD_BITS-1:0];
  end

  always_comb begin
    stage_valid_next = stage_valid;
    if (accept) begin
      stage_valid_next = 1'b1;
    end else if (push) begin
      stage_valid_next = 1'b0;
    end
  end

  // Hold the pen and the staged word
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      pen_col     <= '0;
      pen_row     <= '0;
    end else begin
      stage_valid <= stage_valid_next;
      if (accept) begin
        pen_col <= pen_col_next;
        pen_row <= cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_col   <= cur_col;
      stage_row   <= cur_row;
      stage_code  <= char_code;
      stage_fg    <= fg_color;
      stage_bg    <= bg_color;
      stage_scale <= scale;
    end
  end

  // Classify: clip each column and row, then build the emit mask
  always_comb begin
    logic signed [XW-1:0]              pos;
    clip_t [grr_pkg::GLYPH_CELLS-1:0]  cclip;
    clip_t [grr_pkg::GLYPH_CELLS-1:0]  rclip;
    logic [grr_pkg::CELL_COUNT-1:0]    bits;
    logic                              opaque;
    for (int i = 0; i < grr_pkg::GLYPH_CELLS; i++) begin
      pos      = XW'(stage_col) + XW'(stage_scale) * XW'(i);
      cclip[i] = clip(pos, stage_scale, panel_width);
      pos      = XW'(stage_row) + XW'(stage_scale) * XW'(i);
      rclip[i] = clip(pos, stage_scale, panel_height);
    end
    bits   = grr_pkg::glyph_bits(stage_code);
    opaque = stage_bg != grr_pkg::TRANSPARENT;
    push_entry.glyph = bits;
    push_entry.fg    = stage_fg;
    push_entry.bg    = stage_bg;
    for (int c = 0; c < grr_pkg::GLYPH_CELLS; c++) begin
      push_entry.cols[c] = cclip[c].span;
      push_entry.rows[c] = rclip[c].span;
      for (int r = 0; r < grr_pkg::GLYPH_CELLS; r++) begin
        push_entry.mask[c*grr_pkg::GLYPH_CELLS + r] =
          (bits[c*grr_pkg::GLYPH_CELLS + r] | opaque) & cclip[c].vis & rclip[r].vis;
      end
    end
  end

  a_zero_scale_empty: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage_scale == '0) |-> (push_entry.mask == '0))
    else $error("zero-scale character produced squares");

  a_pen_row_held: assert property (@(posedge clk) disable iff (rst)
    ($past(accept) && !$past(new_string)) |-> (pen_row == $past(pen_row)))
    else $error("pen row moved without a new string");

endmodule

// File: rtl/grr_queue.sv
`timescale 1ns / 1ps
// Short register queue between the front and back ends.
// Depends on grr_pkg for the entry type.
module grr_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  grr_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output grr_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grr_pkg::entry_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

// File: rtl/grr_back.sv
`timescale 1ns / 1ps
// Back end: walks the emit mask of one character, one square per cycle while rect_stall is low.
// Depends on grr_pkg; reads grr_queue, drives the result register.
module grr_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  grr_pkg::entry_t                 head,
  output logic                            pop,
  input  logic [grr_pkg::OFFSET_BITS-1:0] window_x_offset,
  input  logic [grr_pkg::OFFSET_BITS-1:0] window_y_offset,
  output logic                            rect_valid,
  input  logic                            rect_stall,
  output logic [grr_pkg::WIN_BITS-1:0]    win_x0,
  output logic [grr_pkg::WIN_BITS-1:0]    win_y0,
  output logic [grr_pkg::WIN_BITS-1:0]    win_x1,
  output logic [grr_pkg::WIN_BITS-1:0]    win_y1,
  output logic [grr_pkg::COLOR_BITS-1:0]  fill_color,
  output logic [grr_pkg::COUNT_BITS-1:0]  pixel_count,
  output logic                            last_rect
);

  grr_pkg::entry_t                work;
  logic [grr_pkg::CELL_COUNT-1:0] rem;
  logic [grr_pkg::CELL_COUNT-1:0] pick;
  logic                           busy;
  logic                           advance;
  logic                           cell_last;
  logic                           rect_valid_next;
  grr_pkg::span_t                 sel_x;
  grr_pkg::span_t                 sel_y;

  // Lowest remaining cell, which is the next in column-major order
  assign pick      = rem & (~rem + grr_pkg::CELL_COUNT'(1));
  assign busy      = rem != '0;
  assign cell_last = (rem & ~pick) == '0;
  assign advance   = busy & (~rect_valid | ~rect_stall);
  assign pop       = head_valid & (~busy | (advance & cell_last));

  // Select the column and row spans of the picked cell
  always_comb begin
    logic [grr_pkg::GLYPH_CELLS-1:0] col_hit;
    logic [grr_pkg::GLYPH_CELLS-1:0] row_hit;
    row_hit = '0;
    sel_x   = '0;
    sel_y   = '0;
    for (int c = 0; c < grr_pkg::GLYPH_CELLS; c++) begin
      col_hit[c] = |pick[c*grr_pkg::GLYPH_CELLS +: grr_pkg::GLYPH_CELLS];
      row_hit    = row_hit | pick[c*grr_pkg::GLYPH_CELLS +: grr_pkg::GLYPH_CELLS];
    end
    for (int i = 0; i < grr_pkg::GLYPH_CELLS; i++) begin
      sel_x = sel_x | (work.cols[i] & {$bits(grr_pkg::span_t){col_hit[i]}});
      sel_y = sel_y | (work.rows[i] & {$bits(grr_pkg::span_t){row_hit[i]}});
    end
  end

  always_comb begin
    rect_valid_next = rect_valid & rect_stall;
    if (advance) begin
      rect_valid_next = 1'b1;
    end
  end

  // Load a new character or drop the cell just sent
  always_ff @(posedge clk) begin
    if (rst) begin
      rem        <= '0;
      rect_valid <= 1'b0;
    end else begin
      rect_valid <= rect_valid_next;
      if (pop) begin
        rem <= head.mask;
      end else if (advance) begin
        rem <= rem & ~pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      win_x0      <= grr_pkg::WIN_BITS'(sel_x.lo) + grr_pkg::WIN_BITS'(window_x_offset);
      win_x1      <= grr_pkg::WIN_BITS'(sel_x.hi) + grr_pkg::WIN_BITS'(window_x_offset);
      win_y0      <= grr_pkg::WIN_BITS'(sel_y.lo) + grr_pkg::WIN_BITS'(window_y_offset);
      win_y1      <= grr_pkg::WIN_BITS'(sel_y.hi) + grr_pkg::WIN_BITS'(window_y_offset);
      fill_color  <= ((pick & work.glyph) != '0) ? work.fg : work.bg;
      pixel_count <= grr_pkg::COUNT_BITS'(sel_x.len) * grr_pkg::COUNT_BITS'(sel_y.len);
      last_rect   <= cell_last;
    end
  end

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (advance && cell_last) |=> (rect_valid && last_rect))
    else $error("final square of a character not marked last");

  a_nonempty_square: assert property (@(posedge clk) disable iff (rst)
    rect_valid |-> (pixel_count != '0))
    else $error("empty square sent");

endmodule
